// File: src/nlcp_pkg.sv
package nlcp_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned CharWidth  = 8;
    localparam logic [2:0] MaxFracDigits = 3'd5;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_UP_B   = 8'h42;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    localparam logic [7:0] CH_UP_A_OFS = 8'h37;
    localparam logic [7:0] CH_LO_A_OFS = 8'h57;

    localparam logic [31:0] FixedPosMax = 32'h0000_7FFF;
    localparam logic [31:0] FixedNegMin = 32'hFFFF_8000;
    localparam logic [31:0] OctetMax    = 32'd255;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ZERO,
        PH_PREFIX,
        PH_FIRST,
        PH_FRAC,
        PH_THIRD,
        PH_FOURTH
    } t_phase;

    typedef enum logic [1:0] {
        RDX_DEC = 2'd0,
        RDX_HEX = 2'd1,
        RDX_OCT = 2'd2,
        RDX_BIN = 2'd3
    } t_radix;

    typedef struct packed {
        t_phase      phase;
        t_radix      radix;
        logic        negative;
        logic [31:0] first_field;
        logic [31:0] fraction_sum;
        logic [2:0]  fraction_count;
        logic        fraction_open;
        logic [31:0] second_field;
        logic [31:0] third_field;
        logic [31:0] fourth_field;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:          PH_IDLE,
        radix:          RDX_DEC,
        negative:       1'b0,
        first_field:    32'd0,
        fraction_sum:   32'd0,
        fraction_count: 3'd0,
        fraction_open:  1'b1,
        second_field:   32'd0,
        third_field:    32'd0,
        fourth_field:   32'd0
    };

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_digit;

    typedef struct packed {
        logic        emit;
        logic [31:0] value;
    } t_step_out;

    function automatic t_digit digit_of(input logic [7:0] c);
        t_digit d;
        d.valid = 1'b1;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.value = 4'(c - CH_ZERO);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            d.value = 4'(c - CH_UP_A_OFS);
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            d.value = 4'(c - CH_LO_A_OFS);
        end else begin
            d.valid = 1'b0;
            d.value = 4'd0;
        end
        return d;
    endfunction

    function automatic logic [31:0] mul_radix(input logic [31:0] v, input t_radix r);
        logic [31:0] m;
        case (r)
            RDX_HEX: m = v << 4;
            RDX_OCT: m = v << 3;
            RDX_BIN: m = v << 1;
            default: m = (v << 3) + (v << 1);
        endcase
        return m;
    endfunction

    function automatic logic [31:0] frac_weight(input logic [2:0] idx);
        logic [31:0] w;
        case (idx)
            3'd0:    w = 32'd429496730;
            3'd1:    w = 32'd42949673;
            3'd2:    w = 32'd4294968;
            3'd3:    w = 32'd429497;
            3'd4:    w = 32'd42950;
            default: w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

// File: src/nlcp_if.sv
interface nlcp_char_if import nlcp_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CharWidth-1:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface nlcp_value_if import nlcp_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic signed [ValueWidth-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// File: src/nlcp_in_stage.sv
module nlcp_in_stage import nlcp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [CharWidth-1:0] i_character,
    output logic                 o_ready,
    input  logic                 i_fire,
    output logic                 o_valid,
    output logic [CharWidth-1:0] o_character
);

    logic                 r_valid;
    logic [CharWidth-1:0] r_character;
    logic                 w_accept;

    assign o_ready  = !r_valid || i_fire;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_character <= i_character;
        end
    end

    assign o_valid     = r_valid;
    assign o_character = r_character;

endmodule

// File: src/nlcp_step.sv
module nlcp_step import nlcp_pkg::*; (
    input  t_state               i_state,
    input  logic [CharWidth-1:0] i_character,
    output t_state               o_next,
    output t_step_out            o_result
);

    t_digit      w_dig;
    logic        w_first_dot;
    logic        w_dotted_ok;
    logic [31:0] w_first_next;
    logic [31:0] w_fixed;
    logic [16:0] w_frac_round;
    logic [31:0] w_packed3;
    logic [31:0] w_packed4;
    logic [31:0] w_raw;
    logic        w_neg;
    logic        w_prefix_char;
    logic        w_oct_char;
    logic        w_frac_take;
    logic [2:0]  w_count_inc;

    assign w_dig        = digit_of(i_character);
    assign w_first_next = mul_radix(i_state.first_field, i_state.radix)
                          + {28'd0, w_dig.value};
    assign w_first_dot  = (i_character == CH_DOT) && (i_state.radix == RDX_DEC)
                          && (i_state.first_field <= FixedPosMax
                              || i_state.first_field >= FixedNegMin);
    assign w_dotted_ok  = (i_character == CH_DOT) && (i_state.first_field <= OctetMax)
                          && !i_state.negative && (i_state.second_field <= OctetMax);
    assign w_prefix_char = (i_character == CH_LO_X) || (i_character == CH_UP_X)
                          || (i_character == CH_LO_B) || (i_character == CH_UP_B);
    assign w_oct_char   = (i_character >= CH_ZERO) && (i_character <= CH_SEVEN);

    assign w_frac_round = {1'b0, i_state.fraction_sum[31:16]}
                          + {16'd0, |i_state.fraction_sum[15:12]};
    assign w_fixed      = {i_state.first_field[15:0], w_frac_round[15:0]};
    assign w_packed3    = (i_state.first_field << 16) | (i_state.second_field << 8)
                          | i_state.third_field;
    assign w_packed4    = (w_packed3 << 8) | i_state.fourth_field;

    assign w_frac_take  = i_state.fraction_open && (w_dig.value <= 4'd9)
                          && (i_state.fraction_count < MaxFracDigits);
    assign w_count_inc  = i_state.fraction_count + 3'd1;

    // next state
    always_comb begin
        o_next = i_state;
        unique case (i_state.phase)
            PH_IDLE, PH_ZERO, PH_PREFIX, PH_FIRST: begin
                if (i_state.phase == PH_IDLE && i_character == CH_ZERO) begin
                    o_next.phase = PH_ZERO;
                end else if ((i_state.phase == PH_IDLE || i_state.phase == PH_PREFIX)
                             && i_character == CH_MINUS) begin
                    o_next.negative = 1'b1;
                    o_next.phase    = PH_FIRST;
                end else if (i_state.phase == PH_ZERO && w_prefix_char) begin
                    o_next.radix = (i_character == CH_LO_X || i_character == CH_UP_X)
                                   ? RDX_HEX : RDX_BIN;
                    o_next.phase = PH_PREFIX;
                end else if (i_state.phase == PH_ZERO && w_oct_char) begin
                    o_next.radix       = RDX_OCT;
                    o_next.phase       = PH_FIRST;
                    o_next.first_field = mul_radix(i_state.first_field, RDX_OCT)
                                         + {28'd0, w_dig.value};
                end else begin
                    o_next.phase = PH_FIRST;
                    if (w_dig.valid) begin
                        o_next.first_field = w_first_next;
                    end else if (w_first_dot) begin
                        o_next.phase = PH_FRAC;
                    end
                end
            end
            PH_FRAC: begin
                if (w_dig.valid) begin
                    o_next.second_field = mul_radix(i_state.second_field, RDX_DEC)
                                          + {28'd0, w_dig.value};
                    if (w_frac_take) begin
                        o_next.fraction_sum = i_state.fraction_sum
                            + ({28'd0, w_dig.value} * frac_weight(i_state.fraction_count));
                        o_next.fraction_count = w_count_inc;
                        if (w_count_inc >= MaxFracDigits) begin
                            o_next.fraction_open = 1'b0;
                        end
                    end else begin
                        o_next.fraction_open = 1'b0;
                    end
                end else if (w_dotted_ok) begin
                    o_next.phase = PH_THIRD;
                end
            end
            PH_THIRD: begin
                if (w_dig.valid) begin
                    o_next.third_field = mul_radix(i_state.third_field, RDX_DEC)
                                         + {28'd0, w_dig.value};
                end else if (i_character == CH_DOT) begin
                    o_next.phase = PH_FOURTH;
                end
            end
            PH_FOURTH: begin
                if (w_dig.valid) begin
                    o_next.fourth_field = mul_radix(i_state.fourth_field, RDX_DEC)
                                          + {28'd0, w_dig.value};
                end
            end
            default: begin
                o_next = STATE_RESET;
            end
        endcase
    end

    // result
    always_comb begin
        o_result.emit = 1'b0;
        w_raw         = i_state.first_field;
        w_neg         = i_state.negative;
        unique case (i_state.phase)
            PH_IDLE: begin
                o_result.emit = (i_character != CH_ZERO) && (i_character != CH_MINUS)
                                && !w_dig.valid && !w_first_dot;
            end
            PH_ZERO: begin
                o_result.emit = !w_prefix_char && !w_dig.valid && !w_first_dot;
            end
            PH_PREFIX: begin
                o_result.emit = (i_character != CH_MINUS) && !w_dig.valid && !w_first_dot;
            end
            PH_FIRST: begin
                o_result.emit = !w_dig.valid && !w_first_dot;
            end
            PH_FRAC: begin
                o_result.emit = !w_dig.valid && !w_dotted_ok;
                w_raw         = w_fixed;
            end
            PH_THIRD: begin
                o_result.emit = !w_dig.valid && (i_character != CH_DOT);
                w_raw         = w_packed3;
                w_neg         = 1'b0;
            end
            PH_FOURTH: begin
                o_result.emit = !w_dig.valid;
                w_raw         = w_packed4;
                w_neg         = 1'b0;
            end
            default: begin
                o_result.emit = 1'b0;
            end
        endcase
        o_result.value = w_neg ? (32'd0 - w_raw) : w_raw;
    end

endmodule

// File: src/nlcp_out_stage.sv
module nlcp_out_stage import nlcp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  t_step_out             i_result,
    output logic                  o_can_take,
    output logic                  o_valid,
    output logic [ValueWidth-1:0] o_value,
    input  logic                  i_ready
);

    logic                  r_valid;
    logic [ValueWidth-1:0] r_value;
    logic                  w_load;

    assign o_can_take = !r_valid || i_ready;
    assign w_load     = i_fire && i_result.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_value <= i_result.value;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

// File: src/numeric_literal_char_parser.sv
// numeric literal parser, one character transaction per cycle while the output is not stalled
// terminating characters are registered in the input stage, values in the output stage
// throughput: one character per cycle unless the output stalls; the parse state update
// is a single registered pass; a stalled output holds one value while the input register
// still takes one more character
// reset: synchronous active low, clears the parse state and both valid flags
module numeric_literal_char_parser import nlcp_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    nlcp_char_if.sink    i_char,
    nlcp_value_if.source o_value
);

    t_state               r_state;
    t_state               n_state;
    t_step_out            w_result;
    logic                 w_in_valid;
    logic [CharWidth-1:0] w_in_char;
    logic                 w_can_take;
    logic                 w_fire;
    logic [ValueWidth-1:0] w_out_value;

    assign w_fire = w_in_valid && w_can_take;

    nlcp_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_char.valid),
        .i_character (i_char.character),
        .o_ready     (i_char.ready),
        .i_fire      (w_fire),
        .o_valid     (w_in_valid),
        .o_character (w_in_char)
    );

    nlcp_step u_step (
        .i_state     (r_state),
        .i_character (w_in_char),
        .o_next      (n_state),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_fire) begin
            r_state <= w_result.emit ? STATE_RESET : n_state;
        end
    end

    nlcp_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_result   (w_result),
        .o_can_take (w_can_take),
        .o_valid    (o_value.valid),
        .o_value    (w_out_value),
        .i_ready    (o_value.ready)
    );

    assign o_value.value = $signed(w_out_value);

endmodule

// File: src/nlcp_checker.sv
module nlcp_checker import nlcp_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [ValueWidth-1:0] i_out_value
);

    // first cycle after reset shows no value
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("value shown right after reset");

    // an empty output side never blocks characters
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // a value transaction frees the pipe for the next character
    a_ready_on_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |-> i_in_ready)
        else $error("input blocked while output drains");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_value)))
        else $error("stalled value changed or dropped");

endmodule

bind numeric_literal_char_parser nlcp_checker u_nlcp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_char.ready),
    .i_out_valid (o_value.valid),
    .i_out_ready (o_value.ready),
    .i_out_value (o_value.value)
);
